/* design/ltti_pkg.sv */
// shared types, constants and the cordic angle table for the turtle interpreter
// used by the multiplier, the cordic and the top level; no dependencies

package ltti_pkg;

  localparam int FRAC_BITS    = 19;
  localparam int TRIG_BITS    = 29;
  localparam int FIRST_COLOR  = 15;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;

  localparam logic [4:0] CMD_TURN_PLUS   = 5'd0;
  localparam logic [4:0] CMD_TURN_MINUS  = 5'd1;
  localparam logic [4:0] CMD_TURN_AROUND = 5'd2;
  localparam logic [4:0] CMD_FLIP        = 5'd3;
  localparam logic [4:0] CMD_ROTATE      = 5'd4;
  localparam logic [4:0] CMD_ROTATE_BACK = 5'd5;
  localparam logic [4:0] CMD_SCALE       = 5'd6;
  localparam logic [4:0] CMD_DRAW_FREE   = 5'd7;
  localparam logic [4:0] CMD_MOVE_FREE   = 5'd8;
  localparam logic [4:0] CMD_MOVE_STEP   = 5'd9;
  localparam logic [4:0] CMD_DRAW_STEP   = 5'd10;
  localparam logic [4:0] CMD_SET_COLOR   = 5'd11;
  localparam logic [4:0] CMD_COLOR_UP    = 5'd12;
  localparam logic [4:0] CMD_COLOR_DOWN  = 5'd13;
  localparam logic [4:0] CMD_PUSH        = 5'd14;
  localparam logic [4:0] CMD_POP         = 5'd15;
  localparam logic [4:0] CMD_BEGIN       = 5'd16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [2:0] REG_PASS_MODE     = 3'd0;
  localparam logic [2:0] REG_HEADING_COUNT = 3'd1;
  localparam logic [2:0] REG_HEADING_STEP  = 3'd2;
  localparam logic [2:0] REG_ASPECT_RATIO  = 3'd3;
  localparam logic [2:0] REG_COLOR_COUNT   = 3'd4;
  localparam logic [2:0] REG_START_X       = 3'd5;
  localparam logic [2:0] REG_START_Y       = 3'd6;
  localparam logic [2:0] REG_START_SIZE    = 3'd7;

  typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_TRIG} mul_shift_t;

  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
    mul_shift_t  sh;
  } mul_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
    logic [31:0] low;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] theta;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] c;
    logic [31:0] s;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* design/ltti_if.sv */
// command and result channel interfaces for the turtle interpreter
// valid/ready handshake; no dependencies

interface ltti_cmd_if;
  logic        valid;
  logic        ready;
  logic [4:0]  command;
  logic [31:0] amount;
  modport source(output valid, command, amount, input ready);
  modport sink(input valid, command, amount, output ready);
endinterface

interface ltti_res_if;
  logic               valid;
  logic               ready;
  logic               segment_valid;
  logic signed [12:0] from_x;
  logic signed [12:0] from_y;
  logic signed [12:0] to_x;
  logic signed [12:0] to_y;
  logic [7:0]         segment_color;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_y;
  logic [1:0]         status;
  modport source(output valid, segment_valid, from_x, from_y, to_x, to_y, segment_color,
                 box_min_x, box_max_x, box_min_y, box_max_y, status, input ready);
  modport sink(input valid, segment_valid, from_x, from_y, to_x, to_y, segment_color,
               box_min_x, box_max_x, box_min_y, box_max_y, status, output ready);
endinterface

/* design/ltti_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module ltti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ltti_mul.sv */
// shared signed multiplier with registered product, then floor shift and saturation
// depends on ltti_pkg

module ltti_mul (
  input  logic              clk,
  input  ltti_pkg::mul_req_t req,
  output ltti_pkg::mul_rsp_t rsp
);

  logic signed [65:0]   prod;
  ltti_pkg::mul_shift_t sh;
  logic signed [65:0]   v;
  logic                 ovf;

  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
    sh   <= req.sh;
  end

  always_comb begin
    case (sh)
      ltti_pkg::SH_FRAC: v = prod >>> ltti_pkg::FRAC_BITS;
      ltti_pkg::SH_TRIG: v = prod >>> ltti_pkg::TRIG_BITS;
      default:           v = prod;
    endcase
    ovf = !((&v[65:31]) || !(|v[65:31]));
    rsp.ovf = ovf;
    if (ovf) begin
      rsp.res = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      rsp.res = v[31:0];
    end
    rsp.low = prod[31:0];
  end

endmodule

/* design/ltti_cordic.sv */
// iterative cordic, one rotation step per cycle, sine and cosine in q1.29
// depends on ltti_pkg

module ltti_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  ltti_pkg::cordic_req_t req,
  output ltti_pkg::cordic_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [4:0]         cnt;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic [1:0]         quad;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] at;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = $signed(ltti_pkg::atan_val(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      x    <= ltti_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= {2'b00, req.theta[29:0]};
      quad <= req.theta[31:30];
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      if (cnt == 5'(ltti_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 5'd1;
    end
  end

  always_comb begin
    rsp.done = done;
    case (quad)
      2'd0: begin
        rsp.c = x;
        rsp.s = y;
      end
      2'd1: begin
        rsp.c = -y;
        rsp.s = x;
      end
      2'd2: begin
        rsp.c = -x;
        rsp.s = -y;
      end
      default: begin
        rsp.c = y;
        rsp.s = -x;
      end
    endcase
  end

endmodule

/* design/lsystem_turtle_interpreter.sv */
// top level of the turtle interpreter: apb registers, sequencer, save stack
// depends on ltti_pkg, ltti_if, ltti_ram, ltti_mul, ltti_cordic
//
// commands enter on cmd (valid/ready), one result per command leaves on res.
// configuration goes through the apb port, registers at byte address 4*i.
// cmd.ready is high only while the sequencer is idle; one command at a time.
// flips, rotates, color up/down, push, begin, unknown commands and color
// commands in the sizing pass finish straight from the execute state; pop
// adds a stack read; turns repeat a heading-count subtraction until the
// index is in range; set color in the drawing pass forms a bit-serial
// remainder; scale takes one shared multiplier pass; the free moves run the
// 30-step shared cordic and three passes through the shared multiplier,
// step moves the cordic and four passes, the first forming its angle.
// a finished result sits in the output register until res.ready; the next
// command is taken meanwhile, and a further result waits in the sequencer.
// reset restores the configuration registers, clears the turtle state and
// empties the save stack; stack memory and work registers are not reset.

module lsystem_turtle_interpreter #(
  parameter int STACK_DEPTH  = 16,
  parameter int MAX_HEADINGS = 50
) (
  input  logic        clk,
  input  logic        rst,
  ltti_cmd_if.sink    cmd,
  ltti_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 143;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_POP, S_MOD, S_DIV, S_ANGM, S_ANGW, S_CORD,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_POS, S_SCL, S_SCLW, S_FIN
  } state_t;

  typedef enum logic [1:0] {T_UP, T_DOWN, T_AROUND} turn_t;

  // configuration
  logic               pass_mode;
  logic [5:0]         heading_count;
  logic [31:0]        heading_step;
  logic [23:0]        aspect_ratio;
  logic [8:0]         color_count;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [30:0]        start_size;

  // turtle state
  state_t             state;
  turn_t              turn_op;
  logic [4:0]         cmd_r;
  logic [31:0]        amt_r;
  logic [5:0]         heading_index;
  logic               reversed;
  logic [31:0]        free_angle;
  logic [31:0]        step_length;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [7:0]         pen_color;
  logic signed [31:0] bounds [4];
  logic [DW-1:0]      stack_depth;
  logic               math_overflow;

  // work registers
  logic [6:0]         mod_val;
  logic [8:0]         rem;
  logic [4:0]         dcnt;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  logic signed [31:0] t1;
  logic signed [31:0] dx;
  logic [1:0]         stat_r;
  logic               seg_v;
  logic [12:0]        fx;
  logic [12:0]        fy;
  logic [12:0]        tx;
  logic [12:0]        ty;
  logic [7:0]         segc;

  ltti_pkg::mul_req_t    mreq;
  ltti_pkg::mul_rsp_t    mrsp;
  ltti_pkg::cordic_req_t creq;
  ltti_pkg::cordic_rsp_t crsp;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_wdata;
  logic [EW-1:0]      ram_rdata;
  logic [DW-1:0]      depth_m1;

  logic [6:0]         n_eff;
  logic [8:0]         cc;
  logic [8:0]         cc_m1;
  logic [7:0]         first_color;
  logic               is_free;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [9:0]         div_t;
  logic [8:0]         rem_next;
  logic [7:0]         up_col;
  logic [7:0]         dn_col;
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic signed [31:0] npx;
  logic signed [31:0] npy;
  logic               pos_ovf;

  ltti_mul u_mul (.clk(clk), .req(mreq), .rsp(mrsp));
  ltti_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  ltti_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      ltti_pkg::REG_PASS_MODE:     prdata = {31'b0, pass_mode};
      ltti_pkg::REG_HEADING_COUNT: prdata = {26'b0, heading_count};
      ltti_pkg::REG_HEADING_STEP:  prdata = heading_step;
      ltti_pkg::REG_ASPECT_RATIO:  prdata = {8'b0, aspect_ratio};
      ltti_pkg::REG_COLOR_COUNT:   prdata = {23'b0, color_count};
      ltti_pkg::REG_START_X:       prdata = start_x;
      ltti_pkg::REG_START_Y:       prdata = start_y;
      default:                     prdata = {1'b0, start_size};
    endcase
  end

  always_comb begin
    if (heading_count < 6'd3) begin
      n_eff = 7'd3;
    end else if ({1'b0, heading_count} > 7'(MAX_HEADINGS)) begin
      n_eff = 7'(MAX_HEADINGS);
    end else begin
      n_eff = {1'b0, heading_count};
    end
    if (color_count < 9'd2) begin
      cc = 9'd2;
    end else if (color_count > 9'd256) begin
      cc = 9'd256;
    end else begin
      cc = color_count;
    end
    cc_m1 = cc - 9'd1;
    first_color = (cc > 9'(ltti_pkg::FIRST_COLOR)) ? 8'(ltti_pkg::FIRST_COLOR) : cc_m1[7:0];
    is_free = (cmd_r == ltti_pkg::CMD_DRAW_FREE) || (cmd_r == ltti_pkg::CMD_MOVE_FREE);
    div_t = {rem, amt_r[31]};
    rem_next = (div_t >= {1'b0, cc}) ? 9'(div_t - {1'b0, cc}) : div_t[8:0];
    up_col = (pen_color + amt_r[7:0]) & cc_m1[7:0];
    dn_col = (pen_color - amt_r[7:0]) & cc_m1[7:0];
    sum_x = {pos_x[31], pos_x} + {dx[31], dx};
    sum_y = {pos_y[31], pos_y} + {mrsp.res[31], mrsp.res};
    pos_ovf = 1'b0;
    if (sum_x[32] != sum_x[31]) begin
      npx = sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      pos_ovf = 1'b1;
    end else begin
      npx = sum_x[31:0];
    end
    if (sum_y[32] != sum_y[31]) begin
      npy = sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      pos_ovf = 1'b1;
    end else begin
      npy = sum_y[31:0];
    end
  end

  always_comb begin
    mreq.a  = '0;
    mreq.b  = '0;
    mreq.sh = ltti_pkg::SH_NONE;
    case (state)
      S_ANGM: begin
        mreq.a = {27'b0, heading_index};
        mreq.b = {1'b0, heading_step};
      end
      S_SCL: begin
        mreq.a  = {1'b0, step_length};
        mreq.b  = {1'b0, amt_r};
        mreq.sh = ltti_pkg::SH_FRAC;
      end
      S_M1: begin
        mreq.sh = ltti_pkg::SH_FRAC;
        if (is_free) begin
          mreq.a = {1'b0, step_length};
          mreq.b = {9'b0, aspect_ratio};
        end else begin
          mreq.a = {9'b0, aspect_ratio};
          mreq.b = {cos_r[31], cos_r};
        end
      end
      S_M2: begin
        mreq.sh = ltti_pkg::SH_TRIG;
        if (is_free) begin
          mreq.a = {t1[31], t1};
          mreq.b = {cos_r[31], cos_r};
        end else begin
          mreq.a = {1'b0, step_length};
          mreq.b = {t1[31], t1};
        end
      end
      S_M3: begin
        mreq.sh = ltti_pkg::SH_TRIG;
        mreq.a  = {1'b0, step_length};
        mreq.b  = {sin_r[31], sin_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    creq.start = 1'b0;
    creq.theta = free_angle;
    if (state == S_EXEC && is_free) begin
      creq.start = 1'b1;
    end else if (state == S_ANGW) begin
      creq.start = 1'b1;
      creq.theta = mrsp.low;
    end
  end

  assign depth_m1  = stack_depth - DW'(1);
  assign ram_raddr = depth_m1[AW-1:0];
  assign ram_waddr = stack_depth[AW-1:0];
  assign ram_we    = (state == S_EXEC) && (cmd_r == ltti_pkg::CMD_PUSH)
                     && (stack_depth < DW'(STACK_DEPTH));
  assign ram_wdata = {pen_color, step_length, free_angle, reversed, heading_index, pos_y, pos_x};
  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_mode     <= 1'b0;
      heading_count <= 6'd4;
      heading_step  <= 32'd1073741824;
      aspect_ratio  <= 24'd524288;
      color_count   <= 9'd256;
      start_x       <= '0;
      start_y       <= '0;
      start_size    <= 31'd524288;
      state         <= S_IDLE;
      heading_index <= '0;
      reversed      <= 1'b0;
      free_angle    <= '0;
      step_length   <= 32'd524288;
      pos_x         <= '0;
      pos_y         <= '0;
      pen_color     <= 8'(ltti_pkg::FIRST_COLOR);
      for (int i = 0; i < 4; i++) begin
        bounds[i] <= '0;
      end
      stack_depth   <= '0;
      math_overflow <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ltti_pkg::REG_PASS_MODE:     pass_mode <= pwdata[0];
          ltti_pkg::REG_HEADING_COUNT: heading_count <= pwdata[5:0];
          ltti_pkg::REG_HEADING_STEP:  heading_step <= pwdata;
          ltti_pkg::REG_ASPECT_RATIO:  aspect_ratio <= pwdata[23:0];
          ltti_pkg::REG_COLOR_COUNT:   color_count <= pwdata[8:0];
          ltti_pkg::REG_START_X:       start_x <= pwdata;
          ltti_pkg::REG_START_Y:       start_y <= pwdata;
          default:                     start_size <= pwdata[30:0];
        endcase
      end
      if (res.valid && res.ready && state != S_FIN) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r <= cmd.command;
            amt_r <= cmd.amount;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          stat_r <= ltti_pkg::ST_OK;
          seg_v  <= 1'b0;
          fx     <= '0;
          fy     <= '0;
          tx     <= '0;
          ty     <= '0;
          segc   <= '0;
          state  <= S_FIN;
          case (cmd_r)
            ltti_pkg::CMD_TURN_PLUS: begin
              turn_op <= reversed ? T_UP : T_DOWN;
              mod_val <= {1'b0, heading_index};
              state   <= S_MOD;
            end
            ltti_pkg::CMD_TURN_MINUS: begin
              turn_op <= reversed ? T_DOWN : T_UP;
              mod_val <= {1'b0, heading_index};
              state   <= S_MOD;
            end
            ltti_pkg::CMD_TURN_AROUND: begin
              turn_op <= T_AROUND;
              mod_val <= {1'b0, heading_index} + (n_eff >> 1);
              state   <= S_MOD;
            end
            ltti_pkg::CMD_FLIP: reversed <= !reversed;
            ltti_pkg::CMD_ROTATE: begin
              free_angle <= reversed ? free_angle - amt_r : free_angle + amt_r;
            end
            ltti_pkg::CMD_ROTATE_BACK: begin
              free_angle <= reversed ? free_angle + amt_r : free_angle - amt_r;
            end
            ltti_pkg::CMD_SCALE: state <= S_SCL;
            ltti_pkg::CMD_DRAW_FREE, ltti_pkg::CMD_MOVE_FREE: state <= S_CORD;
            ltti_pkg::CMD_MOVE_STEP, ltti_pkg::CMD_DRAW_STEP: state <= S_ANGM;
            ltti_pkg::CMD_SET_COLOR: begin
              if (pass_mode) begin
                rem   <= '0;
                dcnt  <= '0;
                state <= S_DIV;
              end
            end
            ltti_pkg::CMD_COLOR_UP: begin
              if (pass_mode) begin
                pen_color <= (up_col == 8'd0) ? 8'd1 : up_col;
              end
            end
            ltti_pkg::CMD_COLOR_DOWN: begin
              if (pass_mode) begin
                pen_color <= (dn_col == 8'd0) ? cc_m1[7:0] : dn_col;
              end
            end
            ltti_pkg::CMD_PUSH: begin
              if (stack_depth >= DW'(STACK_DEPTH)) begin
                stat_r <= ltti_pkg::ST_FULL;
              end else begin
                stack_depth <= stack_depth + DW'(1);
              end
            end
            ltti_pkg::CMD_POP: begin
              if (stack_depth == '0) begin
                stat_r <= ltti_pkg::ST_EMPTY;
              end else begin
                stack_depth <= depth_m1;
                state       <= S_POP;
              end
            end
            ltti_pkg::CMD_BEGIN: begin
              heading_index <= '0;
              reversed      <= 1'b0;
              free_angle    <= '0;
              step_length   <= {1'b0, start_size};
              pos_x         <= start_x;
              pos_y         <= start_y;
              pen_color     <= first_color;
              for (int i = 0; i < 4; i++) begin
                bounds[i] <= '0;
              end
              stack_depth   <= '0;
              math_overflow <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          pos_x         <= ram_rdata[31:0];
          pos_y         <= ram_rdata[63:32];
          heading_index <= ram_rdata[69:64];
          reversed      <= ram_rdata[70];
          free_angle    <= ram_rdata[102:71];
          step_length   <= ram_rdata[134:103];
          pen_color     <= ram_rdata[142:135];
          state         <= S_FIN;
        end
        S_MOD: begin
          if (mod_val >= n_eff) begin
            mod_val <= mod_val - n_eff;
          end else begin
            case (turn_op)
              T_UP: begin
                heading_index <= (mod_val + 7'd1 == n_eff) ? 6'd0 : 6'(mod_val + 7'd1);
              end
              T_DOWN: begin
                heading_index <= (mod_val == 7'd0) ? 6'(n_eff - 7'd1) : 6'(mod_val - 7'd1);
              end
              default: heading_index <= mod_val[5:0];
            endcase
            state <= S_FIN;
          end
        end
        S_DIV: begin
          rem   <= rem_next;
          amt_r <= {amt_r[30:0], 1'b0};
          dcnt  <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            pen_color <= rem_next[7:0];
            state     <= S_FIN;
          end
        end
        S_ANGM: state <= S_ANGW;
        S_ANGW: state <= S_CORD;
        S_CORD: begin
          if (crsp.done) begin
            cos_r <= crsp.c;
            sin_r <= crsp.s;
            state <= S_M1;
          end
        end
        S_M1: state <= S_M1W;
        S_M1W: begin
          t1 <= mrsp.res;
          if (mrsp.ovf) math_overflow <= 1'b1;
          state <= S_M2;
        end
        S_M2: state <= S_M2W;
        S_M2W: begin
          dx <= mrsp.res;
          if (mrsp.ovf) math_overflow <= 1'b1;
          state <= S_M3;
        end
        S_M3: state <= S_M3W;
        S_M3W: begin
          if (mrsp.ovf || pos_ovf) math_overflow <= 1'b1;
          pos_x <= npx;
          pos_y <= npy;
          if (!pass_mode) begin
            if (npx < bounds[0]) bounds[0] <= npx;
            if (npx > bounds[1]) bounds[1] <= npx;
            if (npy < bounds[2]) bounds[2] <= npy;
            if (npy > bounds[3]) bounds[3] <= npy;
          end else if (cmd_r == ltti_pkg::CMD_DRAW_FREE || cmd_r == ltti_pkg::CMD_DRAW_STEP) begin
            seg_v <= 1'b1;
            fx    <= pos_x[31:19];
            fy    <= pos_y[31:19];
            tx    <= npx[31:19];
            ty    <= npy[31:19];
            segc  <= pen_color;
          end
          state <= S_FIN;
        end
        S_SCL: state <= S_SCLW;
        S_SCLW: begin
          step_length <= mrsp.res;
          if (mrsp.ovf) math_overflow <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.segment_valid <= seg_v;
            res.from_x        <= fx;
            res.from_y        <= fy;
            res.to_x          <= tx;
            res.to_y          <= ty;
            res.segment_color <= segc;
            res.box_min_x     <= bounds[0];
            res.box_max_x     <= bounds[1];
            res.box_min_y     <= bounds[2];
            res.box_max_y     <= bounds[3];
            if (stat_r != ltti_pkg::ST_OK) begin
              res.status <= stat_r;
            end else begin
              res.status <= math_overflow ? ltti_pkg::ST_OVERFLOW : ltti_pkg::ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
